@@ hdl/spcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package spcr_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int NORM_STEPS = 17;
  localparam int TAIL_STAGES = 6;
  localparam int PIPE_DEPTH = 2 + SQRT_STEPS + NORM_STEPS + TAIL_STAGES;

  localparam logic [16:0] RESTITUTION_RESET = 17'd39322;
  localparam logic [17:0] ONE_Q16 = 18'd65536;
  localparam logic [31:0] HALF_WEIGHT = 32'h4000_0000;
  localparam logic [39:0] SAT_SELF = 40'h00_8000_0000;
  localparam logic [39:0] SAT_OTHER = 40'h00_7FFF_FFFF;

  // side data riding along the square root / weight divider stages
  typedef struct packed {
    logic             hit;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [2:0][32:0] dv;
    logic [31:0]      rs;
    logic [32:0]      msum;
  } sqrt_carry_t;

  // side data riding along the normal divider stages
  typedef struct packed {
    logic             hit;
    logic [2:0]       neg;
    logic [2:0][32:0] dv;
    logic [31:0]      len;
    logic [31:0]      pen;
    logic [31:0]      w1;
    logic [31:0]      w2;
  } norm_carry_t;

endpackage
`default_nettype wire

@@ hdl/sphere_pair_collision_response_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one sphere pair per cycle unless a stalled output holds the pipeline;
// the square root resolves one root bit per stage over 32 stages and the unit normal
// one quotient bit per stage over 17.
// A stalled output freezes every stage, so in_stall follows out_stall while a result waits.
// Reset (rst, synchronous) empties the pipeline and sets restitution to 0.6.
module sphere_pair_collision_response_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic signed [31:0] vel_self_x,
  input  logic signed [31:0] vel_self_y,
  input  logic signed [31:0] vel_self_z,
  input  logic signed [31:0] vel_other_x,
  input  logic signed [31:0] vel_other_y,
  input  logic signed [31:0] vel_other_z,
  input  logic        [31:0] mass_self,
  input  logic        [31:0] mass_other,
  input  logic        [31:0] radius_sum,
  input  logic               cfg_we,
  input  logic        [16:0] cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic               approaching,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic signed [31:0] speed_change_self,
  output logic signed [31:0] speed_change_other,
  output logic        [31:0] push_self,
  output logic        [31:0] push_other
);
  import spcr_pkg::*;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  logic [16:0]           restitution;

  assign en        = !(vld[PIPE_DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= RESTITUTION_RESET;
    end else if (cfg_we) begin
      restitution <= cfg_wdata;
    end
  end

  // ---------------- stage 1: magnitudes, squares, velocity difference
  logic signed [31:0] off_in [3];
  logic signed [31:0] vs_in  [3];
  logic signed [31:0] vo_in  [3];
  logic        [31:0] mag_in [3];
  logic        [32:0] dv_in  [3];

  assign off_in[0] = offset_x;
  assign off_in[1] = offset_y;
  assign off_in[2] = offset_z;
  assign vs_in[0]  = vel_self_x;
  assign vs_in[1]  = vel_self_y;
  assign vs_in[2]  = vel_self_z;
  assign vo_in[0]  = vel_other_x;
  assign vo_in[1]  = vel_other_y;
  assign vo_in[2]  = vel_other_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = off_in[i][31] ? 32'(32'd0 - off_in[i]) : off_in[i];
      dv_in[i]  = {vs_in[i][31], vs_in[i]} - {vo_in[i][31], vo_in[i]};
    end
  end

  logic [63:0] s1_sq [3];
  logic [63:0] s1_rs2;
  logic [2:0]  s1_neg;
  logic [31:0] s1_mag [3];
  logic [32:0] s1_dv [3];
  logic [31:0] s1_rs;
  logic [31:0] s1_m1;
  logic [31:0] s1_m2;
  logic [32:0] s1_msum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq[i]  <= 64'(mag_in[i]) * 64'(mag_in[i]);
        s1_mag[i] <= mag_in[i];
        s1_dv[i]  <= dv_in[i];
        s1_neg[i] <= off_in[i][31];
      end
      s1_rs2  <= 64'(radius_sum) * 64'(radius_sum);
      s1_rs   <= radius_sum;
      s1_m1   <= mass_self;
      s1_m2   <= mass_other;
      s1_msum <= {1'b0, mass_self} + {1'b0, mass_other};
    end
  end

  // ---------------- stage 2: squared distance and overlap test
  logic [63:0]  d2_sum;
  logic [63:0]  s2_d2;
  logic [31:0]  s2_m1;
  logic [31:0]  s2_m2;
  sqrt_carry_t  s2_carry;

  assign d2_sum = s1_sq[0] + s1_sq[1] + s1_sq[2];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d2          <= d2_sum;
      s2_m1          <= s1_m1;
      s2_m2          <= s1_m2;
      s2_carry.hit   <= d2_sum < s1_rs2;
      s2_carry.neg   <= s1_neg;
      s2_carry.rs    <= s1_rs;
      s2_carry.msum  <= s1_msum;
      for (int i = 0; i < 3; i++) begin
        s2_carry.mag[i] <= s1_mag[i];
        s2_carry.dv[i]  <= s1_dv[i];
      end
    end
  end

  // ---------------- square root (one root bit per stage) and mass weights
  logic [63:0]  sx  [0:SQRT_STEPS];
  logic [63:0]  sr  [0:SQRT_STEPS];
  logic [32:0]  wr1 [0:SQRT_STEPS];
  logic [32:0]  wr2 [0:SQRT_STEPS];
  logic [31:0]  wq1 [0:SQRT_STEPS];
  logic [31:0]  wq2 [0:SQRT_STEPS];
  sqrt_carry_t  sc  [0:SQRT_STEPS];

  assign sx[0]  = s2_d2;
  assign sr[0]  = '0;
  assign wr1[0] = {2'b00, s2_m1[31:1]};
  assign wr2[0] = {2'b00, s2_m2[31:1]};
  assign wq1[0] = '0;
  assign wq2[0] = '0;
  assign sc[0]  = s2_carry;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic [33:0] a1;
    logic [33:0] a2;

    assign trial = sr[k] + RBIT;
    assign a1 = {wr1[k], (k == 0) ? s2_m1[0] : 1'b0};
    assign a2 = {wr2[k], (k == 0) ? s2_m2[0] : 1'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        sc[k+1] <= sc[k];
        if (sx[k] >= trial) begin
          sx[k+1] <= sx[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + RBIT;
        end else begin
          sx[k+1] <= sx[k];
          sr[k+1] <= sr[k] >> 1;
        end
        if (a1 >= {1'b0, sc[k].msum}) begin
          wr1[k+1] <= 33'(a1 - {1'b0, sc[k].msum});
          wq1[k+1] <= {wq1[k][30:0], 1'b1};
        end else begin
          wr1[k+1] <= a1[32:0];
          wq1[k+1] <= {wq1[k][30:0], 1'b0};
        end
        if (a2 >= {1'b0, sc[k].msum}) begin
          wr2[k+1] <= 33'(a2 - {1'b0, sc[k].msum});
          wq2[k+1] <= {wq2[k][30:0], 1'b1};
        end else begin
          wr2[k+1] <= a2[32:0];
          wq2[k+1] <= {wq2[k][30:0], 1'b0};
        end
      end
    end
  end

  // ---------------- unit normal: offset magnitude * 2^16 / length, one bit per stage
  logic [31:0]  nrem [0:NORM_STEPS][0:2];
  logic [16:0]  nq   [0:NORM_STEPS][0:2];
  norm_carry_t  nc   [0:NORM_STEPS];
  logic [31:0]  sq_len;
  logic         msum_zero;

  assign sq_len    = sr[SQRT_STEPS][31:0];
  assign msum_zero = (sc[SQRT_STEPS].msum == '0);

  always_comb begin
    nc[0].hit = sc[SQRT_STEPS].hit;
    nc[0].neg = sc[SQRT_STEPS].neg;
    nc[0].dv  = sc[SQRT_STEPS].dv;
    nc[0].len = sq_len;
    nc[0].pen = sc[SQRT_STEPS].rs - sq_len;
    nc[0].w1  = msum_zero ? HALF_WEIGHT : wq1[SQRT_STEPS];
    nc[0].w2  = msum_zero ? HALF_WEIGHT : wq2[SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      nrem[0][i] = {1'b0, sc[SQRT_STEPS].mag[i][31:1]};
      nq[0][i]   = '0;
    end
  end

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    logic [32:0] a [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        a[i] = {nrem[k][i], (k == 0) ? sc[SQRT_STEPS].mag[i][0] : 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nc[k+1] <= nc[k];
        for (int i = 0; i < 3; i++) begin
          if (a[i] >= {1'b0, nc[k].len}) begin
            nrem[k+1][i] <= 32'(a[i] - {1'b0, nc[k].len});
            nq[k+1][i]   <= {nq[k][i][15:0], 1'b1};
          end else begin
            nrem[k+1][i] <= a[i][31:0];
            nq[k+1][i]   <= {nq[k][i][15:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- tail: signed normal, dot product, impulse, mass shares
  norm_carry_t ncl;
  assign ncl = nc[NORM_STEPS];

  logic signed [17:0] p1_n [3];
  logic        [32:0] p1_dv [3];
  logic               p1_hit;
  logic        [31:0] p1_w1;
  logic        [31:0] p1_w2;
  logic        [63:0] p1_pw1;
  logic        [63:0] p1_pw2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (ncl.len == '0) begin
          p1_n[i] <= '0;
        end else if (ncl.neg[i]) begin
          p1_n[i] <= 18'(18'd0 - {1'b0, nq[NORM_STEPS][i]});
        end else begin
          p1_n[i] <= {1'b0, nq[NORM_STEPS][i]};
        end
        p1_dv[i] <= ncl.dv[i];
      end
      p1_hit <= ncl.hit;
      p1_w1  <= ncl.w1;
      p1_w2  <= ncl.w2;
      p1_pw1 <= 64'(ncl.pen) * 64'(ncl.w1);
      p1_pw2 <= 64'(ncl.pen) * 64'(ncl.w2);
    end
  end

  logic signed [50:0] p2_prod [3];
  logic signed [17:0] p2_n [3];
  logic               p2_hit;
  logic        [31:0] p2_w1;
  logic        [31:0] p2_w2;
  logic        [63:0] p2_pw1;
  logic        [63:0] p2_pw2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_prod[i] <= $signed(p1_dv[i]) * p1_n[i];
        p2_n[i]    <= p1_n[i];
      end
      p2_hit <= p1_hit;
      p2_w1  <= p1_w1;
      p2_w2  <= p1_w2;
      p2_pw1 <= p1_pw1;
      p2_pw2 <= p1_pw2;
    end
  end

  logic signed [52:0] rel_sum;
  logic signed [52:0] p3_rel;
  logic               p3_appr;
  logic signed [17:0] p3_n [3];
  logic               p3_hit;
  logic        [31:0] p3_w1;
  logic        [31:0] p3_w2;
  logic        [63:0] p3_pw1;
  logic        [63:0] p3_pw2;

  assign rel_sum = 53'(p2_prod[0]) + 53'(p2_prod[1]) + 53'(p2_prod[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_rel  <= rel_sum;
      p3_appr <= p2_hit && (rel_sum > 0);
      p3_n    <= p2_n;
      p3_hit  <= p2_hit;
      p3_w1   <= p2_w1;
      p3_w2   <= p2_w2;
      p3_pw1  <= p2_pw1;
      p3_pw2  <= p2_pw2;
    end
  end

  logic        [17:0] factor;
  logic        [53:0] p4_imp;
  logic               p4_appr;
  logic signed [17:0] p4_n [3];
  logic               p4_hit;
  logic        [31:0] p4_w1;
  logic        [31:0] p4_w2;
  logic        [63:0] p4_pw1;
  logic        [63:0] p4_pw2;

  assign factor = ONE_Q16 + {1'b0, restitution};

  always_ff @(posedge clk) begin
    if (en) begin
      p4_imp  <= 54'(p3_rel[51:16]) * 54'(factor);
      p4_appr <= p3_appr;
      p4_n    <= p3_n;
      p4_hit  <= p3_hit;
      p4_w1   <= p3_w1;
      p4_w2   <= p3_w2;
      p4_pw1  <= p3_pw1;
      p4_pw2  <= p3_pw2;
    end
  end

  // impulse split into 32-bit low and 6-bit high partial products
  logic        [37:0] imp;
  logic        [63:0] p5_lo1;
  logic        [63:0] p5_lo2;
  logic        [37:0] p5_hi1;
  logic        [37:0] p5_hi2;
  logic               p5_appr;
  logic signed [17:0] p5_n [3];
  logic               p5_hit;
  logic        [63:0] p5_pw1;
  logic        [63:0] p5_pw2;

  assign imp = p4_imp[53:16];

  always_ff @(posedge clk) begin
    if (en) begin
      p5_lo1  <= 64'(imp[31:0]) * 64'(p4_w1);
      p5_lo2  <= 64'(imp[31:0]) * 64'(p4_w2);
      p5_hi1  <= 38'(imp[37:32]) * 38'(p4_w1);
      p5_hi2  <= 38'(imp[37:32]) * 38'(p4_w2);
      p5_appr <= p4_appr;
      p5_n    <= p4_n;
      p5_hit  <= p4_hit;
      p5_pw1  <= p4_pw1;
      p5_pw2  <= p4_pw2;
    end
  end

  logic [39:0] dvs;
  logic [39:0] dvo;
  logic [39:0] dvs_sat;
  logic [39:0] dvo_sat;

  assign dvs     = {1'b0, p5_hi2, 1'b0} + 40'(p5_lo2[63:31]);
  assign dvo     = {1'b0, p5_hi1, 1'b0} + 40'(p5_lo1[63:31]);
  assign dvs_sat = (dvs > SAT_SELF) ? SAT_SELF : dvs;
  assign dvo_sat = (dvo > SAT_OTHER) ? SAT_OTHER : dvo;

  always_ff @(posedge clk) begin
    if (en) begin
      hit         <= p5_hit;
      approaching <= p5_appr;
      normal_x    <= p5_hit ? p5_n[0] : '0;
      normal_y    <= p5_hit ? p5_n[1] : '0;
      normal_z    <= p5_hit ? p5_n[2] : '0;
      speed_change_self  <= p5_appr ? 32'(32'd0 - dvs_sat[31:0]) : '0;
      speed_change_other <= p5_appr ? dvo_sat[31:0] : '0;
      push_self   <= p5_hit ? p5_pw2[62:31] : '0;
      push_other  <= p5_hit ? p5_pw1[62:31] : '0;
    end
  end

  a_appr_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && approaching |-> hit)
    else $error("approaching without hit");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> push_self == '0 && push_other == '0 &&
                          speed_change_self == '0 && normal_x == '0)
    else $error("miss result not zero");

  a_self_nonpositive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_change_self[31] || speed_change_self == '0)
    else $error("self speed change positive");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule
`default_nettype wire
